>>> hw/rtl/fifo_block_cache_assert.svh
// ----------------------------------------------------------------------------
// fifo_block_cache_assert.svh
// Assertion macros shared by the block cache RTL.
// ----------------------------------------------------------------------------
`ifndef FIFO_BLOCK_CACHE_ASSERT_SVH
`define FIFO_BLOCK_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FBC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fifo_block_cache assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fifo_block_cache assertion failed");

`endif

>>> hw/rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// Types and constants of the fully associative FIFO block cache.
// ----------------------------------------------------------------------------
package fbc_pkg;

   localparam int MAX_ENTRIES     = 64;
   localparam int BLOCK_WORDS     = 32;
   localparam int DISK_COUNT      = 16;
   localparam int BLOCKS_PER_DISK = 256;
   localparam int MIN_ENTRIES     = 2;

   localparam int DISK_W      = 5;
   localparam int BLK_W       = 9;
   localparam int KEY_W       = DISK_W + BLK_W;
   localparam int WORD_W      = 64;
   localparam int CNT32_W     = 32;
   localparam int ENTRY_CFG_W = 7;

   localparam int SLOT_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int WIDX_W    = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
   localparam int RUN_W     = $clog2(BLOCK_WORDS + 1);
   localparam int MEM_DEPTH = MAX_ENTRIES * BLOCK_WORDS;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   localparam logic [ENTRY_CFG_W-1:0] ENTRIES_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_UPDATE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_MISS    = 3'd1,
      ST_PRESENT = 3'd2,
      ST_RANGE   = 3'd3,
      ST_ABSENT  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_READ_ADDR,
      S_READ_DATA
   } state_type;

   typedef struct packed {
      op_type              opcode;
      logic [DISK_W-1:0]   disk_number;
      logic [BLK_W-1:0]    block_number;
      logic [WORD_W-1:0]   data_word;
      logic                word_last;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [WORD_W-1:0]   read_word;
      logic                result_last;
      logic [CNT32_W-1:0]  hit_total;
      logic [CNT32_W-1:0]  query_total;
      logic                cache_on;
   } rsp_type;

   // Search token that walks the tag chain, one cell per cycle.
   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } token_type;

endpackage

>>> hw/rtl/fbc_tag_cell.sv
// ----------------------------------------------------------------------------
// fbc_tag_cell
// One tag entry: valid bit and key, compares the passing search token.
// ----------------------------------------------------------------------------
module fbc_tag_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [fbc_pkg::SLOT_W-1:0] cell_index,
   input  logic [fbc_pkg::CNT_W-1:0]  live,
   input  fbc_pkg::token_type       tok_in,
   output fbc_pkg::token_type       tok_out,
   input  logic                     wr_en,
   input  logic [fbc_pkg::KEY_W-1:0]  wr_key
);
   import fbc_pkg::*;

   logic              valid_ff;
   logic [KEY_W-1:0]  key_ff;
   token_type         tok_ff;
   token_type         tok_in_q;
   logic              match;

   // lowest matching index wins: a token that already hit passes through
   assign match = valid_ff && (key_ff == tok_in.key) && (CNT_W'(cell_index) < live);

   always_comb begin
      tok_in_q       = tok_in;
      tok_in_q.hit   = tok_in.hit | match;
      tok_in_q.slot  = tok_in.hit ? tok_in.slot : cell_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_ff <= wr_key;
      end
   end

   assign tok_out = tok_ff;

endmodule

>>> hw/rtl/fbc_tag_chain.sv
// ----------------------------------------------------------------------------
// fbc_tag_chain
// Row of tag cells; the search token shifts through one cell a cycle.
// ----------------------------------------------------------------------------
module fbc_tag_chain (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fbc_pkg::CNT_W-1:0]       live,
   input  fbc_pkg::token_type            tok_in,
   output fbc_pkg::token_type            tok_out,
   input  logic [fbc_pkg::MAX_ENTRIES-1:0] wr_sel,
   input  logic [fbc_pkg::KEY_W-1:0]       wr_key
);
   import fbc_pkg::*;

   token_type link [MAX_ENTRIES+1];

   assign link[0] = tok_in;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      fbc_tag_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (SLOT_W'(i)),
         .live       (live),
         .tok_in     (link[i]),
         .tok_out    (link[i+1]),
         .wr_en      (wr_sel[i]),
         .wr_key     (wr_key)
      );
   end

   assign tok_out = link[MAX_ENTRIES];

endmodule

>>> hw/rtl/fbc_block_store.sv
// ----------------------------------------------------------------------------
// fbc_block_store
// Block data memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fbc_block_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [fbc_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [fbc_pkg::WORD_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [fbc_pkg::ADDR_W-1:0]  rd_addr,
   output logic [fbc_pkg::WORD_W-1:0]  rd_data
);
   import fbc_pkg::*;

   logic [WORD_W-1:0] mem [MEM_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/fifo_block_cache.sv
// Lookup: hit/miss once the search token has walked the tag chain, then on a hit
//   each block word in turn (memory read, then output register).
// Insert/update: first word after the same chain walk, further words of the
//   run as each one is accepted. One transaction is worked on at a time.
// Reset (synchronous, active high) clears valid bits, FIFO pointer, counters
//   and run state directly; no clearing pass. Block data stays undefined.
// ----------------------------------------------------------------------------
// fifo_block_cache
// Fully associative block cache keyed by (disk, block) with FIFO replacement.
// ----------------------------------------------------------------------------
`include "fifo_block_cache_assert.svh"

module fifo_block_cache (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  fbc_pkg::req_type                 req_data,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output fbc_pkg::rsp_type                 rsp_data,
   // entry count register
   input  logic                             csr_wr_en,
   input  logic [fbc_pkg::ENTRY_CFG_W-1:0]  csr_wr_data
);
   import fbc_pkg::*;

   // --------------------------------------------------------------------
   // Registers
   // --------------------------------------------------------------------
   state_type              state_ff,      state_in;
   logic [ENTRY_CFG_W-1:0] entries_ff;
   logic [SLOT_W-1:0]      fifo_ff,       fifo_in;
   logic [CNT32_W-1:0]     hit_ff,        hit_in;
   logic [CNT32_W-1:0]     query_ff,      query_in;
   // open insert/update run; count != 0 means a run is open
   logic [RUN_W-1:0]       run_cnt_ff,    run_cnt_in;
   logic [SLOT_W-1:0]      run_slot_ff,   run_slot_in;
   logic                   run_reject_ff, run_reject_in;
   status_type             run_status_ff, run_status_in;
   // latched transaction waiting for the chain walk
   op_type                 op_ff,         op_in;
   logic [KEY_W-1:0]       key_ff,        key_in;
   logic [WORD_W-1:0]      word_ff,       word_in;
   logic                   last_ff,       last_in;
   // hit readout
   logic [WIDX_W-1:0]      rd_k_ff,       rd_k_in;
   logic [SLOT_W-1:0]      rd_slot_ff,    rd_slot_in;
   // output register
   logic                   rsp_valid_ff,  rsp_valid_in;
   rsp_type                rsp_ff,        rsp_in;
   // token launched into the tag chain
   token_type              launch_ff,     launch_in;

   // --------------------------------------------------------------------
   // Combinational signals
   // --------------------------------------------------------------------
   logic [CNT_W-1:0]       live;
   logic                   cache_on;
   logic                   out_free;
   logic                   accept;
   logic                   run_open;
   token_type              tok_out;
   logic [MAX_ENTRIES-1:0] cell_wr;
   logic [SLOT_W-1:0]      alloc_idx;
   logic [SLOT_W-1:0]      alloc_next;
   logic                   in_range;

   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic [WORD_W-1:0]      ram_wr_data;
   logic                   ram_rd_en;
   logic [ADDR_W-1:0]      ram_rd_addr;
   logic [WORD_W-1:0]      ram_rd_data;

   logic                   load;
   status_type             load_status;
   logic [WORD_W-1:0]      load_word;
   logic                   load_last;

   logic                   first_go;
   logic                   first_rej;
   status_type             first_status;
   logic [SLOT_W-1:0]      first_slot;

   function automatic logic [ADDR_W-1:0] word_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [WIDX_W-1:0] widx);
      return ADDR_W'(int'(slot) * BLOCK_WORDS + int'(widx));
   endfunction

   // Effective entry count: register clamped into [2, MAX_ENTRIES].
   always_comb begin
      if (int'(entries_ff) < MIN_ENTRIES) begin
         live = CNT_W'(MIN_ENTRIES);
      end else if (int'(entries_ff) > MAX_ENTRIES) begin
         live = CNT_W'(MAX_ENTRIES);
      end else begin
         live = CNT_W'(entries_ff);
      end
   end

   assign cache_on = (int'(live) > MIN_ENTRIES);

   // A transaction is taken only in idle, and only once the output register
   // is empty or drains this cycle, so any result it causes has room.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign run_open  = (run_cnt_ff != '0);

   // FIFO slot for an insert; a stale pointer past the entry count uses slot 0
   assign alloc_idx  = (CNT_W'(fifo_ff) < live) ? fifo_ff : '0;
   assign alloc_next = ((CNT_W'(alloc_idx) + CNT_W'(1)) >= live) ?
                       '0 : alloc_idx + SLOT_W'(1);

   assign in_range = (int'(key_ff[KEY_W-1:BLK_W]) < DISK_COUNT) &&
                     (int'(key_ff[BLK_W-1:0]) < BLOCKS_PER_DISK);

   // --------------------------------------------------------------------
   // Next state and datapath control
   // --------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      fifo_in       = fifo_ff;
      hit_in        = hit_ff;
      query_in      = query_ff;
      run_cnt_in    = run_cnt_ff;
      run_slot_in   = run_slot_ff;
      run_reject_in = run_reject_ff;
      run_status_in = run_status_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      word_in       = word_ff;
      last_in       = last_ff;
      rd_k_in       = rd_k_ff;
      rd_slot_in    = rd_slot_ff;

      launch_in       = '0;
      launch_in.key   = {req_data.disk_number, req_data.block_number};

      cell_wr     = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = word_addr(run_slot_ff, run_cnt_ff[WIDX_W-1:0]);
      ram_wr_data = req_data.data_word;
      ram_rd_en   = 1'b0;
      ram_rd_addr = word_addr(rd_slot_ff, rd_k_ff);

      load        = 1'b0;
      load_status = ST_OK;
      load_word   = '0;
      load_last   = 1'b1;

      first_go     = 1'b0;
      first_rej    = 1'b0;
      first_status = ST_OK;
      first_slot   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (run_open) begin
                  // next data word of the open run, whatever its opcode holds
                  ram_wr_en  = !run_reject_ff;
                  run_cnt_in = run_cnt_ff + RUN_W'(1);
                  if (req_data.word_last || (int'(run_cnt_ff) + 1 >= BLOCK_WORDS)) begin
                     load          = 1'b1;
                     load_status   = run_status_ff;
                     run_cnt_in    = '0;
                     run_slot_in   = '0;
                     run_reject_in = 1'b0;
                     run_status_in = ST_OK;
                  end
               end else if (req_data.opcode != OP_NONE) begin
                  op_in           = req_data.opcode;
                  key_in          = {req_data.disk_number, req_data.block_number};
                  word_in         = req_data.data_word;
                  last_in         = req_data.word_last;
                  launch_in.valid = 1'b1;
                  state_in        = S_SEARCH;
                  if (req_data.opcode == OP_LOOKUP) begin
                     query_in = query_ff + CNT32_W'(1);
                  end
               end
            end
         end

         S_SEARCH: begin
            if (tok_out.valid) begin
               state_in = S_IDLE;
               unique case (op_ff)
                  OP_LOOKUP: begin
                     if (tok_out.hit) begin
                        hit_in     = hit_ff + CNT32_W'(1);
                        rd_slot_in = tok_out.slot;
                        rd_k_in    = '0;
                        state_in   = S_READ_ADDR;
                     end else begin
                        load        = 1'b1;
                        load_status = ST_MISS;
                     end
                  end
                  OP_INSERT: begin
                     first_go = 1'b1;
                     if (!in_range) begin
                        first_rej    = 1'b1;
                        first_status = ST_RANGE;
                     end else if (tok_out.hit) begin
                        first_rej    = 1'b1;
                        first_status = ST_PRESENT;
                     end else begin
                        // claim slot, key and valid bit on the first word
                        first_slot         = alloc_idx;
                        fifo_in            = alloc_next;
                        cell_wr[alloc_idx] = 1'b1;
                     end
                  end
                  OP_UPDATE: begin
                     first_go = 1'b1;
                     if (tok_out.hit) begin
                        first_slot = tok_out.slot;
                     end else begin
                        first_rej    = 1'b1;
                        first_status = ST_ABSENT;
                     end
                  end
                  default: begin
                  end
               endcase

               if (first_go) begin
                  ram_wr_en   = !first_rej;
                  ram_wr_addr = word_addr(first_slot, '0);
                  ram_wr_data = word_ff;
                  if (last_ff || (BLOCK_WORDS <= 1)) begin
                     load        = 1'b1;
                     load_status = first_status;
                  end else begin
                     run_cnt_in    = RUN_W'(1);
                     run_slot_in   = first_slot;
                     run_reject_in = first_rej;
                     run_status_in = first_status;
                  end
               end
            end
         end

         S_READ_ADDR: begin
            ram_rd_en = 1'b1;
            state_in  = S_READ_DATA;
         end

         S_READ_DATA: begin
            if (out_free) begin
               load        = 1'b1;
               load_status = ST_OK;
               load_word   = ram_rd_data;
               load_last   = (int'(rd_k_ff) == BLOCK_WORDS - 1);
               if (load_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_k_in  = rd_k_ff + WIDX_W'(1);
                  state_in = S_READ_ADDR;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // output register: hold while stalled, load a fresh result when asked
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = load_status;
         rsp_in.read_word   = load_word;
         rsp_in.result_last = load_last;
         rsp_in.hit_total   = hit_in;
         rsp_in.query_total = query_in;
         rsp_in.cache_on    = cache_on;
      end
   end

   // --------------------------------------------------------------------
   // Control registers
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fifo_ff       <= '0;
         hit_ff        <= '0;
         query_ff      <= '0;
         run_cnt_ff    <= '0;
         run_slot_ff   <= '0;
         run_reject_ff <= 1'b0;
         run_status_ff <= ST_OK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fifo_ff       <= fifo_in;
         hit_ff        <= hit_in;
         query_ff      <= query_in;
         run_cnt_ff    <= run_cnt_in;
         run_slot_ff   <= run_slot_in;
         run_reject_ff <= run_reject_in;
         run_status_ff <= run_status_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= ENTRIES_RESET;
      end else if (csr_wr_en) begin
         entries_ff <= csr_wr_data;
      end
   end

   // launch token: only the valid flag needs reset
   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff.valid <= 1'b0;
      end else begin
         launch_ff <= launch_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      word_ff    <= word_in;
      last_ff    <= last_in;
      rd_k_ff    <= rd_k_in;
      rd_slot_ff <= rd_slot_in;
      rsp_ff     <= rsp_in;
   end

   // --------------------------------------------------------------------
   // Tag chain and block memory
   // --------------------------------------------------------------------
   fbc_tag_chain u_tags (
      .clock   (clock),
      .reset   (reset),
      .live    (live),
      .tok_in  (launch_ff),
      .tok_out (tok_out),
      .wr_sel  (cell_wr),
      .wr_key  (key_ff)
   );

   fbc_block_store u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // --------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------
   // the token leaves the chain only while the FSM waits for it
   `FBC_ASSERT_NOW(a_token_in_search, clock, reset, tok_out.valid, state_ff == S_SEARCH)
   // an open run keeps the FSM idle, so no search is started mid-run
   `FBC_ASSERT_NOW(a_run_idle, clock, reset, run_open, state_ff == S_IDLE)
   // the hit counter moves only when a lookup result comes out of the chain
   `FBC_ASSERT_NEXT(a_hit_from_search, clock, reset,
                    !(state_ff == S_SEARCH && tok_out.valid), hit_ff == $past(hit_ff))

endmodule
